[hdl/sgwi_pkg.sv]
// Shared types and constants of the sorted gate window integrator.
package sgwi_pkg;

  localparam int SIG_W      = 24;
  localparam int SUM_W      = 48;
  localparam int COUNT_BITS = 24;
  localparam int MEAN_W     = 24;
  localparam int TS_W       = 64;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Quotient magnitude limits for the signed mean.
  localparam logic [SUM_W-1:0] MEAN_POS_LIM = SUM_W'((64'd1 << (MEAN_W - 1)) - 64'd1);
  localparam logic [SUM_W-1:0] MEAN_NEG_LIM = SUM_W'(64'd1 << (MEAN_W - 1));
  localparam logic signed [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic signed [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

  typedef enum logic [1:0] {
    FN_SAMPLE = 2'd0,
    FN_WINDOW = 2'd1,
    FN_FLUSH  = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_INVALID = 3'd2,
    ST_FULL    = 3'd3,
    ST_SAT     = 3'd4
  } status_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [COUNT_BITS-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [MEAN_W-1:0] mean;
  } div_rsp_t;

endpackage

[hdl/sgwi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sgwi_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/sgwi_div.sv]
// Shared restoring divider: signed sum over unsigned count, one quotient bit per cycle.
module sgwi_div
  import sgwi_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(SUM_W);

  logic                  busy;
  logic                  done;
  logic                  neg;
  logic [STEP_W-1:0]     step;
  logic [SUM_W-1:0]      quo;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dvs;

  logic [COUNT_BITS:0]   rem_sh;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;
  logic signed [MEAN_W-1:0] mean_sat;

  assign rem_sh = {rem, quo[SUM_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign ge     = rem_sh >= {1'b0, dvs};

  // Apply sign and clamp to the mean range.
  always_comb begin
    if (neg) begin
      mean_sat = (quo > MEAN_NEG_LIM) ? MEAN_MIN : -$signed(quo[MEAN_W-1:0]);
    end else begin
      mean_sat = (quo > MEAN_POS_LIM) ? MEAN_MAX : $signed(quo[MEAN_W-1:0]);
    end
  end

  assign rsp.done = done;
  assign rsp.mean = mean_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        neg  <= req.dividend[SUM_W-1];
        quo  <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
        rem  <= '0;
        dvs  <= req.divisor;
        step <= '0;
      end else if (busy) begin
        rem  <= ge ? diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
        quo  <= {quo[SUM_W-2:0], ge};
        step <= step + 1'b1;
        // Finish after the last quotient bit.
        busy <= (step != STEP_W'(SUM_W - 1));
        done <= (step == STEP_W'(SUM_W - 1));
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

[hdl/sorted_gate_window_integrator_unit.sv]
// Top level of the sorted gate window integrator: window queue, sequencer and result register.
//
// Usage: items enter on the s_axis channel; tuser carries the function (sample, new
// window, flush, no-op) and tdata carries ts, sig, window_start and window_end.
// Results leave on the m_axis channel, one per closed window or rejected window;
// tuser carries the status and tlast marks the final result caused by one item.
// A new window is stored in the queue RAM in the cycle it is accepted and the block
// is ready again in the next cycle; a rejected window passes through S_FINAL, which
// loads it into the output register once the output is free, and then the block is ready.
// A no-op, or a sample or flush that finds the queue empty, stays in idle; otherwise
// a sample or flush passes through S_WAIT and S_CHECK. Each closed window returns
// through S_WAIT to S_CHECK, after S_DIV when it holds samples: the mean comes from one
// shared divider that retires one quotient bit per cycle over the 48-bit sum. An item
// that closes windows hands its final result to the output in S_FINAL.
// The input side is ready only in the idle state.
// Reset empties the queue and clears the running sum, count and saturation flag;
// queue contents are not cleared and need no clearing pass. When the receiver
// stalls, the result waits in the output register while the next result is held
// in a pending register, and the sequencer waits until the output frees.
module sorted_gate_window_integrator_unit
  import sgwi_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] ts, [87:64] sig, [151:88] window_start, [215:152] window_end
  input  logic [215:0] s_axis_tdata,
  // [1:0] func
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [47:0] sum, [71:48] count, [95:72] mean
  output logic [95:0]  m_axis_tdata,
  // [2:0] status
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WAIT  = 5'b00010,
    S_CHECK = 5'b00100,
    S_DIV   = 5'b01000,
    S_FINAL = 5'b10000
  } state_t;

  state_t state;

  // Queue bookkeeping and running integration of the head window.
  logic [AW-1:0]         head_ptr;
  logic [AW-1:0]         tail_ptr;
  logic [FW-1:0]         fill;
  logic signed [SUM_W-1:0] run_sum;
  logic [COUNT_BITS-1:0] run_count;
  logic                  count_sat;

  // Latched item.
  func_t                 cur_func;
  logic [TS_W-1:0]       cur_ts;
  logic signed [SIG_W-1:0] cur_sig;

  // Pending result, held until it is known whether another result follows.
  logic                  pend_valid;
  logic signed [SUM_W-1:0] pend_sum;
  logic [COUNT_BITS-1:0] pend_count;
  logic signed [MEAN_W-1:0] pend_mean;
  status_t               pend_status;

  // Input fields.
  func_t                 in_func;
  logic [TS_W-1:0]       in_ts;
  logic [SIG_W-1:0]      in_sig;
  logic [TS_W-1:0]       in_ws;
  logic [TS_W-1:0]       in_we;

  assign in_func = func_t'(s_axis_tuser);
  assign in_ts   = s_axis_tdata[63:0];
  assign in_sig  = s_axis_tdata[87:64];
  assign in_ws   = s_axis_tdata[151:88];
  assign in_we   = s_axis_tdata[215:152];

  logic accept;
  logic out_free;
  logic queue_full;
  logic win_ok;
  logic wr_en;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign queue_full    = (fill == FW'(QUEUE_DEPTH));
  assign win_ok        = in_ws < in_we;
  assign wr_en         = accept && (in_func == FN_WINDOW) && win_ok && !queue_full;

  // Head entry of the queue, read through the registered RAM port in the cycle after the head pointer settles.
  logic [2*TS_W-1:0] head_entry;
  logic [TS_W-1:0]   head_start;
  logic [TS_W-1:0]   head_end;

  sgwi_ram #(
    .WIDTH (2 * TS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_ptr),
    .wr_data ({in_we, in_ws}),
    .rd_addr (head_ptr),
    .rd_data (head_entry)
  );

  assign head_start = head_entry[TS_W-1:0];
  assign head_end   = head_entry[2*TS_W-1:TS_W];

  logic closes;
  logic in_win;
  logic close_go;
  logic out_load;

  assign closes   = (fill != '0) && ((cur_func == FN_FLUSH) || (head_end <= cur_ts));
  assign in_win   = (fill != '0) && (cur_func == FN_SAMPLE) &&
                    (head_start <= cur_ts) && (cur_ts < head_end);
  // A close may proceed once an earlier pending result can move to the output.
  assign close_go = (state == S_CHECK) && closes && (!pend_valid || out_free);
  // Load the output register with an earlier result or with the final one.
  assign out_load = (close_go && pend_valid) || ((state == S_FINAL) && out_free);

  // Saturating accumulate of the sample signal.
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;

  assign sum_wide = {run_sum[SUM_W-1], run_sum} + (SUM_W + 1)'(cur_sig);

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign div_req.start    = close_go && (run_count != '0);
  assign div_req.dividend = run_sum;
  assign div_req.divisor  = run_count;

  sgwi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head_ptr      <= '0;
      tail_ptr      <= '0;
      fill          <= '0;
      run_sum       <= '0;
      run_count     <= '0;
      count_sat     <= 1'b0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Raise valid on a load, drop the output item once taken.
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            cur_func <= in_func;
            cur_ts   <= in_ts;
            cur_sig  <= in_sig;
            case (in_func)
              FN_SAMPLE, FN_FLUSH: begin
                if (fill != '0) begin
                  state <= S_WAIT;
                end
              end
              FN_WINDOW: begin
                if (!win_ok || queue_full) begin
                  pend_sum    <= '0;
                  pend_count  <= '0;
                  pend_mean   <= '0;
                  pend_status <= win_ok ? ST_FULL : ST_INVALID;
                  pend_valid  <= 1'b1;
                  state       <= S_FINAL;
                end else begin
                  tail_ptr <= ptr_inc(tail_ptr);
                  fill     <= fill + 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_WAIT: begin
          state <= S_CHECK;
        end

        S_CHECK: begin
          if (closes) begin
            if (close_go) begin
              // Push the earlier result out; it is not the last one.
              if (pend_valid) begin
                m_axis_tdata  <= {pend_mean, pend_count, pend_sum};
                m_axis_tuser  <= pend_status;
                m_axis_tlast  <= 1'b0;
              end
              pend_sum    <= run_sum;
              pend_count  <= run_count;
              pend_status <= count_sat ? ST_SAT :
                             ((run_count == '0) ? ST_EMPTY : ST_OK);
              run_sum     <= '0;
              run_count   <= '0;
              count_sat   <= 1'b0;
              head_ptr    <= ptr_inc(head_ptr);
              fill        <= fill - 1'b1;
              if (run_count == '0) begin
                pend_mean  <= '0;
                pend_valid <= 1'b1;
                state      <= S_WAIT;
              end else begin
                pend_valid <= 1'b0;
                state      <= S_DIV;
              end
            end
          end else begin
            if (in_win) begin
              if (run_count == COUNT_MAX) begin
                count_sat <= 1'b1;
              end else begin
                run_sum   <= sum_sat;
                run_count <= run_count + 1'b1;
              end
            end
            state <= pend_valid ? S_FINAL : S_IDLE;
          end
        end

        S_DIV: begin
          if (div_rsp.done) begin
            pend_mean  <= div_rsp.mean;
            pend_valid <= 1'b1;
            state      <= S_WAIT;
          end
        end

        S_FINAL: begin
          if (out_free) begin
            m_axis_tdata  <= {pend_mean, pend_count, pend_sum};
            m_axis_tuser  <= pend_status;
            m_axis_tlast  <= 1'b1;
            pend_valid    <= 1'b0;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Queue occupancy never exceeds its depth.
  assert property (@(posedge clk) disable iff (rst) fill <= FW'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  // No pending result is left behind when the block goes idle.
  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> !pend_valid)
    else $error("pending result stranded in idle");

  // Divider results arrive only while the sequencer waits for them.
  assert property (@(posedge clk) disable iff (rst) div_rsp.done |-> (state == S_DIV))
    else $error("divider done outside divide wait");

  // Saturation flag is set only with a full count.
  assert property (@(posedge clk) disable iff (rst) count_sat |-> (run_count == COUNT_MAX))
    else $error("count saturation flag without full count");

endmodule
